// ===== hdl/bdte_pkg.sv =====
// shared types, constants and helpers for the bcd date/time to epoch converter
// no dependencies
package bdte_pkg;

  localparam int DayW = 17;   // day count since 1970 for years up to 2165
  localparam int TodW = 21;   // signed seconds within a day, hour may be shifted
  localparam int TzW  = 5;

  localparam logic [33:0] SecsDay  = 34'd86400;
  localparam logic [TodW-1:0] SecsHour = TodW'(3600);
  localparam logic [TodW-1:0] SecsMin  = TodW'(60);
  localparam logic [8:0] DaysYear = 9'd365;
  localparam logic [8:0] EpochYearOfs = 9'd30;   // 2000 - 1970

  localparam logic [7:0] MonthFirst = 8'd1;
  localparam logic [7:0] MonthLast  = 8'd12;
  localparam logic [3:0] MonthFeb   = 4'd1;

  typedef struct packed {
    logic [DayW-1:0] days;
    logic [TodW-1:0] tod;   // two's complement
    logic            bad;
  } bdte_split_t;

  // v - (v >> 4) * 6, kept to 8 bits
  function automatic logic [7:0] bcd_decode(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'd0, v[7:4]};
    return v - ((hi << 2) + (hi << 1));
  endfunction

  // day offset of each month start, february counted as 29 days
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd60;
      4'd3:    return 9'd91;
      4'd4:    return 9'd121;
      4'd5:    return 9'd152;
      4'd6:    return 9'd182;
      4'd7:    return 9'd213;
      4'd8:    return 9'd244;
      4'd9:    return 9'd274;
      4'd10:   return 9'd305;
      4'd11:   return 9'd335;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ===== hdl/bcd_datetime_to_epoch_seconds.sv =====
// bcd rtc date/time to seconds since 1970, two register stages
// a request goes through stage one, then the output stage; throughput: one request per cycle unless the output stalls
// stage one holds the day count and time of day, stage two the day multiply and final sum
// rst (synchronous) empties both stages and sets the timezone offset to zero
// depends on bdte_pkg and bdte_split
module bcd_datetime_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,      // tz_offset_hours, signed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // epoch_seconds
  output logic        m_axis_tuser    // bad_month
);
  import bdte_pkg::*;

  logic [TzW-1:0] tz_offset_hours;
  bdte_split_t split;
  bdte_split_t p1;
  logic p1_valid;
  logic advance;
  logic [33:0] day_secs;
  logic [31:0] epoch_next;

  bdte_split u_split (
    .year_bcd        (s_axis_tdata[7:0]),
    .month_bcd       (s_axis_tdata[15:8]),
    .day_bcd         (s_axis_tdata[23:16]),
    .hour_bcd        (s_axis_tdata[31:24]),
    .minute_bcd      (s_axis_tdata[39:32]),
    .second_bcd      (s_axis_tdata[47:40]),
    .tz_offset_hours (tz_offset_hours),
    .split           (split)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !p1_valid || advance;

  always_comb begin
    day_secs   = {{(34-DayW){1'b0}}, p1.days} * SecsDay;
    epoch_next = day_secs[31:0] + {{(32-TodW){p1.tod[TodW-1]}}, p1.tod};
    if (p1.bad) begin
      epoch_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_offset_hours <= '0;
    end else if (cfg_we) begin
      tz_offset_hours <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        p1_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      p1 <= split;
    end
    if (advance && p1_valid) begin
      m_axis_tdata <= epoch_next;
      m_axis_tuser <= p1.bad;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !p1_valid && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("bad month result carries nonzero seconds");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    p1_valid && !advance |=> p1_valid && $stable(p1))
    else $error("stage one request lost while output stalled");

  a_bad_flows: assert property (@(posedge clk) disable iff (rst)
    p1_valid && advance && p1.bad |=> m_axis_tvalid && m_axis_tuser)
    else $error("bad month flag not carried to output");

endmodule

// ===== hdl/bdte_split.sv =====
// decodes the bcd fields and splits the date into a day count and a time of day
// depends on bdte_pkg
module bdte_split (
  input  logic [7:0]                 year_bcd,
  input  logic [7:0]                 month_bcd,
  input  logic [7:0]                 day_bcd,
  input  logic [7:0]                 hour_bcd,
  input  logic [7:0]                 minute_bcd,
  input  logic [7:0]                 second_bcd,
  input  logic [bdte_pkg::TzW-1:0]   tz_offset_hours,
  output bdte_pkg::bdte_split_t      split
);
  import bdte_pkg::*;

  logic [7:0] yy, mo, dd, hr, mi, ss;
  logic [8:0] years;
  logic [3:0] m;
  logic [DayW-1:0] days;
  logic signed [9:0] hh;
  logic signed [TodW-1:0] hh_w, mi_w, ss_w, tod;
  logic leap_adj;
  logic bad;

  always_comb begin
    yy = bcd_decode(year_bcd);
    mo = bcd_decode(month_bcd);
    dd = bcd_decode(day_bcd);
    hr = bcd_decode(hour_bcd);
    mi = bcd_decode(minute_bcd);
    ss = bcd_decode(second_bcd);

    bad   = (mo < MonthFirst) || (mo > MonthLast);
    m     = 4'(mo - MonthFirst);
    years = {1'b0, yy} + EpochYearOfs;
    // years + 2 is a multiple of four exactly when yy is
    leap_adj = (m > MonthFeb) && (yy[1:0] != 2'd0);

    days = DayW'(years) * DayW'(DaysYear)
         + DayW'((years + 9'd1) >> 2)
         + DayW'(month_start(m))
         + DayW'(dd)
         - DayW'(1)
         - DayW'(leap_adj);

    hh   = $signed({2'b00, hr}) - $signed({{5{tz_offset_hours[TzW-1]}}, tz_offset_hours});
    hh_w = TodW'(hh);
    mi_w = $signed({13'd0, mi});
    ss_w = $signed({13'd0, ss});
    tod  = hh_w * $signed(SecsHour) + mi_w * $signed(SecsMin) + ss_w;

    split.days = days;
    split.tod  = tod;
    split.bad  = bad;
  end

endmodule

// ===== tb/tb_bcd_datetime_to_epoch_seconds.sv =====
`timescale 1ns / 1ps
// testbench for bcd_datetime_to_epoch_seconds: directed and random bcd date/time requests
// checked against an in-bench epoch predictor, with random stalls on both streams
// depends on bdte_pkg and the dut sources
module tb_bcd_datetime_to_epoch_seconds;
  import bdte_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int StallLimit  = 4000;
  localparam int MaxReports  = 10;
  localparam int DrainCycles = 8;
  localparam int SecsMinute  = 60;
  localparam int SecsHr      = 3600;
  localparam int SecsOneDay  = 86400;
  localparam int SecsNoLeap  = 365 * 86400;
  localparam int MonthStartDays [12] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

  typedef struct packed {
    logic [31:0] secs;
    logic        bad;
  } epoch_result_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [TzW-1:0] cfg_wdata = '0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [47:0]    s_axis_tdata = '0;  // year, month, day, hour, minute, second (bcd)
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [31:0]    m_axis_tdata;       // epoch_seconds
  logic           m_axis_tuser;       // bad_month

  logic signed [TzW-1:0] tz_hours = '0;
  epoch_result_t pending_epochs[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  bcd_datetime_to_epoch_seconds dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  function automatic int bcd_value(input logic [7:0] v);
    logic [7:0] t;
    t = v - 8'({4'd0, v[7:4]} * 8'd6);
    return int'(t);
  endfunction

  function automatic epoch_result_t predict_epoch(input logic [47:0] req,
                                                  input logic signed [TzW-1:0] tz);
    int yy, mo, dd, hh, mi, ss;
    longint years, secs;
    epoch_result_t r;
    yy = bcd_value(req[7:0]);
    mo = bcd_value(req[15:8]);
    dd = bcd_value(req[23:16]);
    hh = bcd_value(req[31:24]) - int'(tz);
    mi = bcd_value(req[39:32]);
    ss = bcd_value(req[47:40]);
    if (mo < 1 || mo > 12) begin
      r.secs = '0;
      r.bad = 1'b1;
      return r;
    end
    years = 30 + yy;
    secs = SecsNoLeap * years + SecsOneDay * ((years + 1) / 4)
         + SecsOneDay * longint'(MonthStartDays[mo - 1]);
    // table counts february as 29 days
    if (mo > 2 && (years + 2) % 4 != 0)
      secs -= SecsOneDay;
    secs += SecsOneDay * longint'(dd - 1) + SecsHr * longint'(hh)
          + SecsMinute * longint'(mi) + longint'(ss);
    r.secs = secs[31:0];
    r.bad = 1'b0;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // result check first, then the prediction for a request taken at the same edge
  always @(posedge clk) begin
    epoch_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_epochs.size() == 0) begin
          note_mismatch("unexpected result", -1, m_axis_tdata);
        end else begin
          want = pending_epochs.pop_front();
          if (m_axis_tdata !== want.secs)
            note_mismatch("epoch_seconds", want.secs, m_axis_tdata);
          if (m_axis_tuser !== want.bad)
            note_mismatch("bad_month", want.bad, m_axis_tuser);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_epochs.push_back(predict_epoch(s_axis_tdata, tz_hours));
    end
  end

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // counts cycles with work outstanding but no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && pending_epochs.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_bcd_datetime_to_epoch_seconds: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic [47:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_tz(input logic signed [TzW-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tz_hours = v;
  endtask

  function automatic logic [47:0] datetime(input logic [7:0] yy, input logic [7:0] mo,
                                           input logic [7:0] dd, input logic [7:0] hh,
                                           input logic [7:0] mi, input logic [7:0] ss);
    return {ss, mi, hh, dd, mo, yy};
  endfunction

  // mostly well-formed bcd, sometimes any byte
  function automatic logic [7:0] rand_bcd(input int lo, input int hi);
    int v;
    if ($urandom_range(99) < 12)
      return 8'($urandom_range(255));
    v = $urandom_range(hi, lo);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [47:0] rand_request();
    return datetime(rand_bcd(0, 99), rand_bcd(1, 12), rand_bcd(1, 31),
                    rand_bcd(0, 23), rand_bcd(0, 59), rand_bcd(0, 59));
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_request(rand_request());
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(datetime(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
    send_request(datetime(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
    send_request(datetime(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));  // month zero
    send_request(datetime(8'h24, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));  // leap day
    send_request(datetime(8'h24, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
    send_request(datetime(8'h23, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
    send_request(datetime(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_request(datetime(8'h50, 8'h13, 8'h15, 8'h10, 8'h10, 8'h10));  // month thirteen
    send_request(datetime(8'h50, 8'h0a, 8'h15, 8'h10, 8'h10, 8'h10));  // non-bcd month, valid
    send_request(datetime(8'h50, 8'h1f, 8'h15, 8'h10, 8'h10, 8'h10));
    // every month, with out-of-range day, hour, minute and second values
    for (int m = 1; m <= 12; m++)
      send_request(datetime(8'h01, {4'(m / 10), 4'(m % 10)}, 8'hff, 8'h99, 8'hff, 8'h9f));
    // hour goes negative and large after the offset
    write_tz(TzW'(15));
    send_request(datetime(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
    write_tz(TzW'(-16));
    send_request(datetime(8'h99, 8'h12, 8'hff, 8'hff, 8'hff, 8'hff));
    wait_drained();
  endtask

  task automatic test_tz_sweep();
    int tz_points [7] = '{-16, -12, -1, 0, 1, 14, 15};
    send_idle_pct = 18;
    recv_idle_pct = 46;
    foreach (tz_points[i]) begin
      write_tz(TzW'(tz_points[i]));
      send_random(50);
    end
    wait_drained();
  endtask

  task automatic test_idle_mix();
    write_tz(TzW'(-5));
    send_idle_pct = 18;
    recv_idle_pct = 46;
    send_random(250);
    send_idle_pct = 46;
    recv_idle_pct = 18;
    send_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(250);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold while requests keep coming, so the pipe fills
    hold_req = 300;
    send_random(40);
    wait_drained();
    recv_idle_pct = 46;
    send_random(80);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_tz_sweep();
    test_idle_mix();
    test_backpressure();
    if (mismatches == 0 && pending_epochs.size() == 0) begin
      $display("tb_bcd_datetime_to_epoch_seconds: clean");
    end else begin
      $display("tb_bcd_datetime_to_epoch_seconds: errors");
    end
    $finish;
  end

endmodule
